// ===== rtl/core/rdx_pkg.sv =====
// Package for the RV32I decode/execute unit: item, state and result types,
// opcode, status and CSR address constants, and the memory window test.
// No dependencies.
`timescale 1ns / 1ps

package rdx_pkg;

  localparam int unsigned CSR_COUNT = 4096;
  localparam int unsigned CSR_AW    = 12;

  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_WAIT  = 3'd1;
  localparam logic [2:0] ST_EXIT  = 3'd2;
  localparam logic [2:0] ST_BREAK = 3'd3;
  localparam logic [2:0] ST_PCOUT = 3'd4;
  localparam logic [2:0] ST_BAD   = 3'd5;

  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  localparam logic [1:0] CFG_ENTRY_PC   = 2'd0;
  localparam logic [1:0] CFG_INITIAL_SP = 2'd1;
  localparam logic [1:0] CFG_MEM_BASE   = 2'd2;

  localparam logic [CSR_AW-1:0] CSR_MCYCLE    = 12'hB00;
  localparam logic [CSR_AW-1:0] CSR_MCYCLEH   = 12'hB80;
  localparam logic [CSR_AW-1:0] CSR_MINSTRET  = 12'hB02;
  localparam logic [CSR_AW-1:0] CSR_MINSTRETH = 12'hB82;

  localparam logic [31:0] ECALL_EXIT = 32'd93;
  localparam logic [4:0]  REG_SP     = 5'd2;
  localparam logic [4:0]  REG_A0     = 5'd10;
  localparam logic [4:0]  REG_A7     = 5'd17;

  typedef struct packed {
    logic        action;
    logic [31:0] instr;
    logic [31:0] load_data;
  } item_t;

  typedef struct packed {
    logic [31:0] pc;
    logic        pend_vld;
    logic [2:0]  pend_f3;
    logic [4:0]  pend_rd;
    logic        halted;
  } core_state_t;

  typedef struct packed {
    logic              rf_we;
    logic [4:0]        rf_addr;
    logic [31:0]       rf_data;
    logic              csr_we;
    logic [CSR_AW-1:0] csr_idx;
    logic [31:0]       csr_data;
  } wb_t;

  typedef struct packed {
    logic [1:0]  mem_request;
    logic [31:0] mem_address;
    logic [31:0] mem_write_data;
    logic [1:0]  access_size;
    logic [31:0] pc_next;
    logic [2:0]  status;
    logic [31:0] exit_code;
  } result_t;

  function automatic logic in_window(input logic [31:0] addr, input logic [31:0] base,
                                     input logic [31:0] last);
    logic [31:0] off;
    off = addr - base;
    return off <= last;
  endfunction

endpackage

// ===== rtl/core/rdx_exec.sv =====
// Decode and execute logic for one transaction: result, write-back and next state.
// Depends on rdx_pkg.
`timescale 1ns / 1ps

module rdx_exec import rdx_pkg::*; #(
  parameter longint unsigned MEM_BYTES = 67108864
) (
  input  item_t       item_i,
  input  core_state_t state_i,
  input  logic [31:0] op_a_i,
  input  logic [31:0] op_b_i,
  input  logic [31:0] csr_old_i,
  input  logic [63:0] count_i,
  input  logic [31:0] mem_base_i,
  input  logic [31:0] x10_i,
  input  logic [31:0] x17_i,
  output result_t     res_o,
  output core_state_t state_o,
  output logic [63:0] count_o,
  output wb_t         wb_o
);

  localparam logic [31:0] Last1 = 32'(MEM_BYTES - 1);
  localparam logic [31:0] Last2 = 32'(MEM_BYTES - 2);
  localparam logic [31:0] Last4 = 32'(MEM_BYTES - 4);

  always_comb begin
    logic [31:0] ins, a, b, immi, imms, immb, immj, immu, npc, ea, rdv, old, src, nv, lv;
    logic [31:0] last;
    logic [6:0]  op, f7;
    logic [4:0]  rd, r1, sh;
    logic [2:0]  f3;
    logic [63:0] cnt_n;
    logic        we, taken, sz_ok;
    logic [1:0]  sz;

    ins   = item_i.instr;
    a     = op_a_i;
    b     = op_b_i;
    op    = ins[6:0];
    rd    = ins[11:7];
    f3    = ins[14:12];
    r1    = ins[19:15];
    f7    = ins[31:25];
    immi  = {{20{ins[31]}}, ins[31:20]};
    imms  = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    immb  = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    immj  = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    immu  = {ins[31:12], 12'b0};
    sh    = immi[4:0];
    npc   = state_i.pc + 32'd4;
    cnt_n = count_i + 64'd1;
    ea    = '0;
    rdv   = '0;
    we    = 1'b0;
    taken = 1'b0;
    sz_ok = 1'b0;
    sz    = SZ_BYTE;
    last  = Last1;
    src   = '0;
    nv    = '0;
    lv    = '0;

    unique case (ins[31:20])
      CSR_MCYCLE, CSR_MINSTRET:   old = cnt_n[31:0];
      CSR_MCYCLEH, CSR_MINSTRETH: old = cnt_n[63:32];
      default:                    old = csr_old_i;
    endcase

    res_o   = '0;
    res_o.pc_next = state_i.pc;
    state_o = state_i;
    count_o = count_i;
    wb_o    = '0;

    if (state_i.halted || (item_i.action != state_i.pend_vld)) begin
      res_o.status = ST_BAD;
    end else if (item_i.action) begin
      unique case (state_i.pend_f3)
        3'd0:    lv = {{24{item_i.load_data[7]}}, item_i.load_data[7:0]};
        3'd1:    lv = {{16{item_i.load_data[15]}}, item_i.load_data[15:0]};
        3'd2:    lv = item_i.load_data;
        3'd4:    lv = {24'b0, item_i.load_data[7:0]};
        default: lv = {16'b0, item_i.load_data[15:0]};
      endcase
      wb_o.rf_we       = state_i.pend_rd != 5'd0;
      wb_o.rf_addr     = state_i.pend_rd;
      wb_o.rf_data     = lv;
      state_o.pend_vld = 1'b0;
      state_o.pend_f3  = '0;
      state_o.pend_rd  = '0;
      if (!in_window(state_i.pc, mem_base_i, Last4)) begin
        state_o.halted = 1'b1;
        res_o.status   = ST_PCOUT;
      end
    end else if (!in_window(state_i.pc, mem_base_i, Last4)) begin
      state_o.halted = 1'b1;
      res_o.status   = ST_PCOUT;
    end else begin
      count_o = cnt_n;
      unique case (op)
        OP_LOAD: begin
          ea = a + immi;
          unique case (f3)
            3'd0, 3'd4: begin sz_ok = 1'b1; sz = SZ_BYTE; last = Last1; end
            3'd1, 3'd5: begin sz_ok = 1'b1; sz = SZ_HALF; last = Last2; end
            3'd2:       begin sz_ok = 1'b1; sz = SZ_WORD; last = Last4; end
            default:    sz_ok = 1'b0;
          endcase
          if (sz_ok) begin
            if (in_window(ea, mem_base_i, last)) begin
              res_o.mem_request = REQ_READ;
              res_o.mem_address = ea;
              res_o.access_size = sz;
              res_o.status      = ST_WAIT;
              state_o.pend_vld  = 1'b1;
              state_o.pend_f3   = f3;
              state_o.pend_rd   = rd;
            end else begin
              we  = 1'b1;
              rdv = '0;
            end
          end
        end
        OP_IMM: begin
          we = 1'b1;
          unique case (f3)
            3'd0: rdv = a + immi;
            3'd1: begin we = f7 == F7_BASE; rdv = a << sh; end
            3'd2: rdv = {31'b0, $signed(a) < $signed(immi)};
            3'd3: rdv = {31'b0, a < immi};
            3'd4: rdv = a ^ immi;
            3'd5: begin
              we  = (f7 == F7_BASE) || (f7 == F7_ALT);
              rdv = (f7 == F7_ALT) ? 32'($signed(a) >>> sh) : a >> sh;
            end
            3'd6: rdv = a | immi;
            default: rdv = a & immi;
          endcase
        end
        OP_AUIPC: begin we = 1'b1; rdv = state_i.pc + immu; end
        OP_LUI:   begin we = 1'b1; rdv = immu; end
        OP_STORE: begin
          ea = a + imms;
          unique case (f3)
            3'd0:    begin sz_ok = 1'b1; sz = SZ_BYTE; last = Last1; end
            3'd1:    begin sz_ok = 1'b1; sz = SZ_HALF; last = Last2; end
            3'd2:    begin sz_ok = 1'b1; sz = SZ_WORD; last = Last4; end
            default: sz_ok = 1'b0;
          endcase
          if (sz_ok && in_window(ea, mem_base_i, last)) begin
            res_o.mem_request = REQ_WRITE;
            res_o.mem_address = ea;
            res_o.access_size = sz;
            unique case (sz)
              SZ_BYTE: res_o.mem_write_data = {24'b0, b[7:0]};
              SZ_HALF: res_o.mem_write_data = {16'b0, b[15:0]};
              default: res_o.mem_write_data = b;
            endcase
          end
        end
        OP_REG: begin
          if (f7 == F7_BASE) begin
            we = 1'b1;
            unique case (f3)
              3'd0: rdv = a + b;
              3'd1: rdv = a << b[4:0];
              3'd2: rdv = {31'b0, $signed(a) < $signed(b)};
              3'd3: rdv = {31'b0, a < b};
              3'd4: rdv = a ^ b;
              3'd5: rdv = a >> b[4:0];
              3'd6: rdv = a | b;
              default: rdv = a & b;
            endcase
          end else if (f7 == F7_ALT) begin
            if (f3 == 3'd0) begin
              we = 1'b1; rdv = a - b;
            end else if (f3 == 3'd5) begin
              we = 1'b1; rdv = 32'($signed(a) >>> b[4:0]);
            end
          end
        end
        OP_BRANCH: begin
          unique case (f3)
            3'd0:    taken = a == b;
            3'd1:    taken = a != b;
            3'd4:    taken = $signed(a) < $signed(b);
            3'd5:    taken = $signed(a) >= $signed(b);
            3'd6:    taken = a < b;
            3'd7:    taken = a >= b;
            default: taken = 1'b0;
          endcase
          if (taken) npc = state_i.pc + immb;
        end
        OP_JALR: begin
          if (f3 == 3'd0) begin
            we  = 1'b1;
            rdv = state_i.pc + 32'd4;
            ea  = a + immi;
            npc = {ea[31:1], 1'b0};
          end
        end
        OP_JAL: begin
          we  = 1'b1;
          rdv = state_i.pc + 32'd4;
          npc = state_i.pc + immj;
        end
        OP_SYSTEM: begin
          if (f3 == 3'd0) begin
            if (immi == 32'd0 && x17_i == ECALL_EXIT) begin
              state_o.halted  = 1'b1;
              res_o.status    = ST_EXIT;
              res_o.exit_code = x10_i;
            end else if (immi == 32'd1) begin
              res_o.status = ST_BREAK;
            end
          end else if (f3 != 3'd4) begin
            src = f3[2] ? {27'b0, r1} : a;
            unique case (f3[1:0])
              2'd1:    nv = src;
              2'd2:    nv = old | src;
              default: nv = old & ~src;
            endcase
            we            = 1'b1;
            rdv           = old;
            wb_o.csr_we   = 1'b1;
            wb_o.csr_idx  = ins[31:20];
            wb_o.csr_data = nv;
          end
        end
        default: ;
      endcase
      wb_o.rf_we   = we && (rd != 5'd0);
      wb_o.rf_addr = rd;
      wb_o.rf_data = rdv;
      state_o.pc   = npc;
      res_o.pc_next = npc;
      if (res_o.status != ST_EXIT && res_o.status != ST_WAIT &&
          !in_window(npc, mem_base_i, Last4)) begin
        state_o.halted = 1'b1;
        res_o.status   = ST_PCOUT;
      end
    end
  end

endmodule

// ===== rtl/core/rv32i_decode_execute_unit.sv =====
// Top level of the RV32I + Zicsr decode/execute unit: operand and CSR memories,
// architectural state, handshakes and result register. Depends on rdx_pkg, rdx_exec.
`timescale 1ns / 1ps

// Channel   | Signals                                       | Direction
// ----------+-----------------------------------------------+----------
// item in   | in_valid_i, in_stall_o, action_i, instr_word_i,| in
//           | load_data_i                                   |
// result    | out_valid_o, out_stall_i, mem_request_o, ...  | out
// config    | cfg_valid_i, cfg_ready_o, cfg_index_i,        | in
//           | cfg_data_i                                    |
//
// One transaction per cycle while in_stall_o is low: operands and CSR are read into the input stage on
// acceptance, executed in one pass and held in the result register.
// An accepted item passes the input stage and then the result register.
// After reset the CSR memory is cleared, one entry a cycle, all 4096 entries with
// in_stall_o high. Configuration writes are taken at any time with no item in flight.
// A stalled result holds the execute stage, which in turn stalls the input.

module rv32i_decode_execute_unit import rdx_pkg::*; #(
  parameter longint unsigned MEM_BYTES = 67108864
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] instr_word_i,
  input  logic [31:0] load_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  mem_request_o,
  output logic [31:0] mem_address_o,
  output logic [31:0] mem_write_data_o,
  output logic [1:0]  access_size_o,
  output logic [31:0] pc_next_o,
  output logic [2:0]  status_o,
  output logic [31:0] exit_code_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0]       rf_mem [32];
  logic [31:0]       rf_vld_q;
  logic [31:0]       csr_mem [CSR_COUNT];
  logic              s1_vld_q;
  item_t             s1_item_q;
  logic [31:0]       op_a_q, op_b_q, byp_data_q, csr_rd_q, csr_byp_data_q;
  logic              a_vld_q, b_vld_q, byp_a_q, byp_b_q, csr_byp_q;
  core_state_t       state_q, state_d;
  logic [63:0]       count_q, count_d;
  logic [31:0]       mem_base_q, x10_q, x17_q;
  logic              clr_busy_q;
  logic [CSR_AW-1:0] clr_idx_q;
  logic              out_vld_q;
  result_t           res_q, res_d;
  wb_t               wb;
  logic              s1_adv, in_acc, cfg_acc;
  logic              rf_we;
  logic [4:0]        rf_wa;
  logic [31:0]       rf_wd, op_a, op_b, csr_old;
  logic [4:0]        rs1, rs2;
  logic [CSR_AW-1:0] csr_ra;

  assign s1_adv      = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = clr_busy_q || cfg_valid_i || (s1_vld_q && !s1_adv);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !s1_vld_q;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  assign rs1    = instr_word_i[19:15];
  assign rs2    = instr_word_i[24:20];
  assign csr_ra = instr_word_i[31:20];

  // Write port shared between execute write-back and the stack pointer setup.
  always_comb begin
    rf_we = s1_adv && wb.rf_we;
    rf_wa = wb.rf_addr;
    rf_wd = wb.rf_data;
    if (cfg_acc && cfg_index_i == CFG_INITIAL_SP) begin
      rf_we = 1'b1;
      rf_wa = REG_SP;
      rf_wd = cfg_data_i;
    end
  end

  assign op_a    = byp_a_q ? byp_data_q : (a_vld_q ? op_a_q : '0);
  assign op_b    = byp_b_q ? byp_data_q : (b_vld_q ? op_b_q : '0);
  assign csr_old = csr_byp_q ? csr_byp_data_q : csr_rd_q;

  rdx_exec #(
    .MEM_BYTES(MEM_BYTES)
  ) u_exec (
    .item_i    (s1_item_q),
    .state_i   (state_q),
    .op_a_i    (op_a),
    .op_b_i    (op_b),
    .csr_old_i (csr_old),
    .count_i   (count_q),
    .mem_base_i(mem_base_q),
    .x10_i     (x10_q),
    .x17_i     (x17_q),
    .res_o     (res_d),
    .state_o   (state_d),
    .count_o   (count_d),
    .wb_o      (wb)
  );

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
    if (in_acc) begin
      op_a_q <= rf_mem[rs1];
      op_b_q <= rf_mem[rs2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      csr_mem[clr_idx_q] <= '0;
    end else if (s1_adv && wb.csr_we) begin
      csr_mem[wb.csr_idx] <= wb.csr_data;
    end
    if (in_acc) begin
      csr_rd_q <= csr_mem[csr_ra];
    end
  end

  // Bypass what the execute stage writes in the same cycle as the read.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q      <= '{action: action_i, instr: instr_word_i, load_data: load_data_i};
      a_vld_q        <= rf_vld_q[rs1];
      b_vld_q        <= rf_vld_q[rs2];
      byp_a_q        <= rf_we && (rf_wa == rs1);
      byp_b_q        <= rf_we && (rf_wa == rs2);
      byp_data_q     <= rf_wd;
      csr_byp_q      <= s1_adv && wb.csr_we && (wb.csr_idx == csr_ra);
      csr_byp_data_q <= wb.csr_data;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q   <= '0;
      s1_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      state_q    <= '0;
      count_q    <= '0;
      mem_base_q <= '0;
      x10_q      <= '0;
      x17_q      <= '0;
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (&clr_idx_q) clr_busy_q <= 1'b0;
      end
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
        count_q   <= count_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (rf_we) begin
        rf_vld_q[rf_wa] <= 1'b1;
        if (rf_wa == REG_A0) x10_q <= rf_wd;
        if (rf_wa == REG_A7) x17_q <= rf_wd;
      end
      if (cfg_acc) begin
        unique case (cfg_index_i)
          CFG_ENTRY_PC: state_q.pc <= cfg_data_i;
          CFG_MEM_BASE: mem_base_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o      = out_vld_q;
  assign mem_request_o    = res_q.mem_request;
  assign mem_address_o    = res_q.mem_address;
  assign mem_write_data_o = res_q.mem_write_data;
  assign access_size_o    = res_q.access_size;
  assign pc_next_o        = res_q.pc_next;
  assign status_o         = res_q.status;
  assign exit_code_o      = res_q.exit_code;

endmodule

// ===== rtl/core/rdx_checker.sv =====
// Port-level checks for the RV32I decode/execute unit, bound to the top level.
// Depends on rdx_pkg and rv32i_decode_execute_unit.
`timescale 1ns / 1ps

module rdx_checker import rdx_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  mem_request_o,
  input logic [31:0] mem_address_o,
  input logic [1:0]  access_size_o,
  input logic [2:0]  status_o,
  input logic [31:0] exit_code_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  a_cfg_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |-> !(in_valid_i && !in_stall_o))
    else $error("configuration write and item taken together");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_no_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mem_request_o == REQ_NONE) |-> (mem_address_o == '0 && access_size_o == SZ_BYTE))
    else $error("access fields set without a request");

  a_exit_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_EXIT) |-> exit_code_o == '0)
    else $error("exit code without exit");

endmodule

bind rv32i_decode_execute_unit rdx_checker u_rdx_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .mem_request_o(mem_request_o),
  .mem_address_o(mem_address_o),
  .access_size_o(access_size_o),
  .status_o     (status_o),
  .exit_code_o  (exit_code_o),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for rv32i_decode_execute_unit: instruction and load-data
// stimulus, an in-order prediction of every result, and field-wise checking.
// Depends on rdx_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module testbench;
  import rdx_pkg::*;

  localparam longint unsigned MEM_BYTES = 67108864;
  localparam int CYCLE_LIMIT = 600000;

  localparam logic [2:0] F3_B = 3'd0, F3_H = 3'd1, F3_W = 3'd2, F3_BU = 3'd4, F3_HU = 3'd5;
  localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6;
  localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_PRIV = 3'd0, F3_CSRRW = 3'd1, F3_CSRRS = 3'd2;
  localparam logic [2:0] F3_CSR_RSVD = 3'd4, F3_CSRRCI = 3'd7;
  localparam logic [1:0] CSR_OP_RW = 2'd1, CSR_OP_RS = 2'd2;
  localparam logic [11:0] IMM_ECALL = 12'd0, IMM_EBREAK = 12'd1;
  localparam logic [11:0] CSR_SCRATCH = 12'h340;
  localparam logic [6:0] OP_UNKNOWN = 7'h7F;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_vld = 1'b0;
  logic        in_act = 1'b0;
  logic [31:0] in_instr = '0;
  logic [31:0] in_ld = '0;
  logic        out_stall = 1'b0;
  logic        cfg_vld = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [31:0] cfg_dat = '0;

  logic        in_stall_o, out_valid_o, cfg_ready_o;
  logic [1:0]  mem_request_o, access_size_o;
  logic [31:0] mem_address_o, mem_write_data_o, pc_next_o, exit_code_o;
  logic [2:0]  status_o;

  rv32i_decode_execute_unit #(.MEM_BYTES(MEM_BYTES)) i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_vld), .in_stall_o,
    .action_i(in_act), .instr_word_i(in_instr), .load_data_i(in_ld),
    .out_valid_o, .out_stall_i(out_stall),
    .mem_request_o, .mem_address_o, .mem_write_data_o, .access_size_o,
    .pc_next_o, .status_o, .exit_code_o,
    .cfg_valid_i(cfg_vld), .cfg_ready_o, .cfg_index_i(cfg_idx), .cfg_data_i(cfg_dat)
  );

  // Shadow architectural state
  logic [31:0] entry_pc = '0, initial_sp = '0, mem_base = '0;
  logic [31:0] rf [32];
  logic [31:0] csr [CSR_COUNT];
  logic [31:0] pc;
  logic [63:0] retired;
  logic        pend_vld, halt_f;
  logic [2:0]  pend_f3;
  logic [4:0]  pend_rd;

  // Snapshot for rejecting random instructions that would halt the core
  logic [31:0] rf_s [32];
  logic [31:0] csr_s [CSR_COUNT];
  logic [31:0] pc_s;
  logic [63:0] retired_s;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      errors = 0;
  int      accepted = 0;
  int      cycles = 0;

  function automatic logic win(input logic [31:0] ad, input int unsigned nb);
    logic [31:0] off;
    off = ad - mem_base;
    return off <= 32'(MEM_BYTES - nb);
  endfunction

  function automatic result_t execute_item(input logic act, input logic [31:0] w,
                                           input logic [31:0] ld);
    result_t r;
    logic [6:0] op, f7;
    logic [4:0] rd, r1, r2;
    logic [2:0] f3;
    logic [31:0] a, b, immi, imms, immb, immj, immu, npc, ea, v, old, src, nv;
    logic [11:0] ci;
    int unsigned n;
    logic t;
    r = '0;
    if (halt_f || (act != pend_vld)) begin
      r.status = ST_BAD;
      r.pc_next = pc;
      return r;
    end
    if (act) begin
      case (pend_f3)
        F3_B:    v = {{24{ld[7]}}, ld[7:0]};
        F3_H:    v = {{16{ld[15]}}, ld[15:0]};
        F3_W:    v = ld;
        F3_BU:   v = {24'b0, ld[7:0]};
        default: v = {16'b0, ld[15:0]};
      endcase
      rf[pend_rd] = v;
      rf[0] = '0;
      pend_vld = 1'b0;
      if (!win(pc, 4)) begin
        halt_f = 1'b1;
        r.status = ST_PCOUT;
      end
      r.pc_next = pc;
      return r;
    end
    if (!win(pc, 4)) begin
      halt_f = 1'b1;
      r.status = ST_PCOUT;
      r.pc_next = pc;
      return r;
    end
    op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; r1 = w[19:15]; r2 = w[24:20]; f7 = w[31:25];
    a = rf[r1]; b = rf[r2];
    immi = {{20{w[31]}}, w[31:20]};
    imms = {{20{w[31]}}, w[31:25], w[11:7]};
    immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    immu = {w[31:12], 12'b0};
    npc = pc + 32'd4;
    retired = retired + 64'd1;
    csr[CSR_MCYCLE] = retired[31:0];
    csr[CSR_MCYCLEH] = retired[63:32];
    csr[CSR_MINSTRET] = retired[31:0];
    csr[CSR_MINSTRETH] = retired[63:32];
    case (op)
      OP_LOAD: begin
        ea = a + immi;
        n = (f3 == F3_B || f3 == F3_BU) ? 1 : (f3 == F3_H || f3 == F3_HU) ? 2 :
            (f3 == F3_W) ? 4 : 0;
        if (n != 0) begin
          if (win(ea, n)) begin
            r.mem_request = REQ_READ;
            r.mem_address = ea;
            r.access_size = (n == 4) ? SZ_WORD : (n == 2) ? SZ_HALF : SZ_BYTE;
            r.status = ST_WAIT;
            pend_vld = 1'b1; pend_f3 = f3; pend_rd = rd;
          end else begin
            rf[rd] = '0;
          end
        end
      end
      OP_IMM: begin
        case (f3)
          F3_ADD:  rf[rd] = a + immi;
          F3_SLL:  if (f7 == F7_BASE) rf[rd] = a << immi[4:0];
          F3_SLT:  rf[rd] = {31'b0, $signed(a) < $signed(immi)};
          F3_SLTU: rf[rd] = {31'b0, a < immi};
          F3_XOR:  rf[rd] = a ^ immi;
          F3_SR: begin
            if (f7 == F7_BASE) rf[rd] = a >> immi[4:0];
            else if (f7 == F7_ALT) rf[rd] = $signed(a) >>> immi[4:0];
          end
          F3_OR:   rf[rd] = a | immi;
          default: rf[rd] = a & immi;
        endcase
      end
      OP_AUIPC: rf[rd] = pc + immu;
      OP_LUI:   rf[rd] = immu;
      OP_STORE: begin
        ea = a + imms;
        n = (f3 == F3_B) ? 1 : (f3 == F3_H) ? 2 : (f3 == F3_W) ? 4 : 0;
        if (n != 0 && win(ea, n)) begin
          r.mem_request = REQ_WRITE;
          r.mem_address = ea;
          r.access_size = (n == 4) ? SZ_WORD : (n == 2) ? SZ_HALF : SZ_BYTE;
          r.mem_write_data = (n == 1) ? {24'b0, b[7:0]} : (n == 2) ? {16'b0, b[15:0]} : b;
        end
      end
      OP_REG: begin
        if (f7 == F7_BASE) begin
          case (f3)
            F3_ADD:  rf[rd] = a + b;
            F3_SLL:  rf[rd] = a << b[4:0];
            F3_SLT:  rf[rd] = {31'b0, $signed(a) < $signed(b)};
            F3_SLTU: rf[rd] = {31'b0, a < b};
            F3_XOR:  rf[rd] = a ^ b;
            F3_SR:   rf[rd] = a >> b[4:0];
            F3_OR:   rf[rd] = a | b;
            default: rf[rd] = a & b;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == F3_ADD) rf[rd] = a - b;
          else if (f3 == F3_SR) rf[rd] = $signed(a) >>> b[4:0];
        end
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  t = (a == b);
          F3_BNE:  t = (a != b);
          F3_BLT:  t = $signed(a) < $signed(b);
          F3_BGE:  t = !($signed(a) < $signed(b));
          F3_BLTU: t = a < b;
          3'd7:    t = a >= b;
          default: t = 1'b0;
        endcase
        if (t) npc = pc + immb;
      end
      OP_JALR: begin
        if (f3 == F3_ADD) begin
          npc = (a + immi) & ~32'd1;
          rf[rd] = pc + 32'd4;
        end
      end
      OP_JAL: begin
        rf[rd] = pc + 32'd4;
        npc = pc + immj;
      end
      OP_SYSTEM: begin
        if (f3 == F3_PRIV) begin
          if (w[31:20] == IMM_ECALL && rf[REG_A7] == ECALL_EXIT) begin
            halt_f = 1'b1;
            r.status = ST_EXIT;
            r.exit_code = rf[REG_A0];
          end else if (w[31:20] == IMM_EBREAK) begin
            r.status = ST_BREAK;
          end
        end else if (f3 != F3_CSR_RSVD) begin
          ci = w[31:20];
          old = csr[ci];
          src = f3[2] ? {27'b0, r1} : a;
          case (f3[1:0])
            CSR_OP_RW: nv = src;
            CSR_OP_RS: nv = old | src;
            default:   nv = old & ~src;
          endcase
          rf[rd] = old;
          csr[ci] = nv;
        end
      end
      default: ;
    endcase
    rf[0] = '0;
    pc = npc;
    if (r.status != ST_EXIT && r.status != ST_WAIT && !win(npc, 4)) begin
      halt_f = 1'b1;
      r.status = ST_PCOUT;
    end
    r.pc_next = pc;
    return r;
  endfunction

  function automatic void push_item(input logic act, input logic [31:0] w,
                                    input logic [31:0] ld);
    item_t it;
    it.action = act; it.instr = w; it.load_data = ld;
    expected_results.insert(expected_results.size(), execute_item(act, w, ld));
    pending_items.insert(pending_items.size(), it);
  endfunction

  // Issue an instruction unless it would halt the core; roll the state back if so
  function automatic logic try_instr(input logic [31:0] w);
    item_t   it;
    result_t r;
    rf_s = rf; csr_s = csr; pc_s = pc; retired_s = retired;
    r = execute_item(1'b0, w, $urandom);
    if (halt_f) begin
      rf = rf_s; csr = csr_s; pc = pc_s; retired = retired_s;
      halt_f = 1'b0; pend_vld = 1'b0;
      return 1'b0;
    end
    it.action = 1'b0; it.instr = w; it.load_data = $urandom;
    pending_items.insert(pending_items.size(), it);
    expected_results.insert(expected_results.size(), r);
    return 1'b1;
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] r1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [6:0] op);
    return {imm, r1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] r2,
                                        input logic [4:0] r1, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [6:0] op);
    return {f7, r2, r1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] r2,
                                        input logic [4:0] r1, input logic [2:0] f3);
    return {imm[11:5], r2, r1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] i, input logic [4:0] r2,
                                        input logic [4:0] r1, input logic [2:0] f3);
    return {i[12], i[10:5], r2, r1, f3, i[4:1], i[11], OP_BRANCH};
  endfunction

  // Prefer a base register that already points into the window
  function automatic logic [4:0] addr_reg();
    logic [4:0] s;
    s = 5'($urandom);
    if ($urandom_range(0, 3) != 0)
      for (int i = 0; i < 32; i++)
        if (win(rf[5'(s + i)], 4)) return 5'(s + i);
    return s;
  endfunction

  function automatic logic [6:0] pick_f7();
    case ($urandom_range(0, 3))
      0, 2:    return F7_BASE;
      1:       return F7_ALT;
      default: return 7'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_instr();
    int unsigned k;
    logic [4:0] rd, r1, r2;
    logic [2:0] f3;
    logic [11:0] imm, ca;
    int o;
    k = $urandom_range(0, 99);
    rd = 5'($urandom); r1 = 5'($urandom); r2 = 5'($urandom);
    f3 = 3'($urandom); imm = 12'($urandom);
    if (k < 15) begin
      if (f3 == F3_SLL || f3 == F3_SR) imm = {pick_f7(), imm[4:0]};
      return enc_i(imm, r1, f3, rd, OP_IMM);
    end
    if (k < 30) return enc_r(pick_f7(), r2, r1, f3, rd, OP_REG);
    if (k < 35) return {20'($urandom), rd, $urandom_range(0, 1) ? OP_LUI : OP_AUIPC};
    if (k < 47) return enc_i($urandom_range(0, 1) ? imm : 12'($urandom_range(0, 15)),
                             addr_reg(), f3, rd, OP_LOAD);
    if (k < 57) return enc_s($urandom_range(0, 1) ? imm : 12'($urandom_range(0, 15)),
                             r2, addr_reg(), f3);
    if (k < 67) begin
      o = (int'($urandom_range(0, 40)) - 20) * 4;
      return enc_b(13'(o), r2, r1, f3);
    end
    if (k < 71) begin
      o = (int'($urandom_range(0, 2000)) - 1000) * 4;
      return {o[20], o[10:1], o[11], o[19:12], rd, OP_JAL};
    end
    if (k < 74) return enc_i(imm, addr_reg(), $urandom_range(0, 3) == 0 ? f3 : F3_ADD,
                             rd, OP_JALR);
    if (k < 87) begin
      case ($urandom_range(0, 5))
        0:       ca = CSR_MCYCLE;
        1:       ca = CSR_MCYCLEH;
        2:       ca = CSR_MINSTRET;
        3:       ca = CSR_MINSTRETH;
        4:       ca = CSR_SCRATCH + 12'($urandom_range(0, 3));
        default: ca = 12'($urandom);
      endcase
      return enc_i(ca, r1, 3'($urandom_range(1, 7)), rd, OP_SYSTEM);
    end
    if (k < 92) begin
      case ($urandom_range(0, 2))
        0:       imm = IMM_ECALL;
        1:       imm = IMM_EBREAK;
        default: ;
      endcase
      return enc_i(imm, r1, F3_PRIV, rd, OP_SYSTEM);
    end
    return $urandom;
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 65) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_vld <= 1'b1;
    cfg_idx <= idx;
    cfg_dat <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_vld <= 1'b0;
    case (idx)
      CFG_ENTRY_PC:   begin entry_pc = val; pc = val; end
      CFG_INITIAL_SP: begin initial_sp = val; rf[REG_SP] = val; end
      default:        mem_base = val;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic report(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Driver: offer the next pending transaction once the current one is taken
  int unsigned in_gap = 0;
  always @(posedge clk_i) begin
    item_t it;
    if (!in_vld || !in_stall_o) begin
      if (in_gap != 0) begin
        in_vld <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        in_vld <= 1'b1;
        in_act <= it.action;
        in_instr <= it.instr;
        in_ld <= it.load_data;
        in_gap <= draw_gap();
      end else begin
        in_vld <= 1'b0;
      end
    end
  end

  // Receiver stall, with one long hold-off to back the unit up
  int unsigned stall_left = 0, hold_left = 0;
  logic        hold_done = 1'b0;
  always @(posedge clk_i) begin
    int unsigned g;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted >= 200) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      g = draw_gap();
      out_stall <= (g != 0);
      stall_left <= (g != 0) ? g - 1 : 0;
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && !out_stall) begin
      accepted++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: status %0d pc_next %h",
                 $time, status_o, pc_next_o);
      end else begin
        e = expected_results.pop_front();
        report("mem_request", 32'(e.mem_request), 32'(mem_request_o));
        report("mem_address", e.mem_address, mem_address_o);
        report("mem_write_data", e.mem_write_data, mem_write_data_o);
        report("access_size", 32'(e.access_size), 32'(access_size_o));
        report("pc_next", e.pc_next, pc_next_o);
        report("status", 32'(e.status), 32'(status_o));
        report("exit_code", e.exit_code, exit_code_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] tgt, hi;
    logic [4:0]  rd;
    for (int i = 0; i < 32; i++) rf[i] = '0;
    for (int i = 0; i < CSR_COUNT; i++) csr[i] = '0;
    pc = '0; retired = '0; pend_vld = 1'b0; pend_f3 = '0; pend_rd = '0; halt_f = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: immediate extremes, shifts, compares, every load width, byte and word stores, CSRs, system ops
    push_item(1'b0, enc_i(12'h800, 5'd0, F3_ADD, 5'd1, OP_IMM), '0);
    push_item(1'b0, enc_i(12'h7FF, 5'd0, F3_ADD, 5'd3, OP_IMM), '0);
    push_item(1'b0, {20'hFFFFF, 5'd4, OP_LUI}, '0);
    push_item(1'b0, {20'h80000, 5'd5, OP_AUIPC}, '0);
    push_item(1'b0, enc_i({F7_ALT, 5'd31}, 5'd1, F3_SR, 5'd6, OP_IMM), '0);
    push_item(1'b0, enc_i({F7_BASE, 5'd31}, 5'd3, F3_SLL, 5'd8, OP_IMM), '0);
    push_item(1'b0, enc_r(F7_ALT, 5'd3, 5'd0, F3_ADD, 5'd9, OP_REG), '0);
    push_item(1'b0, enc_r(F7_ALT, 5'd3, 5'd1, F3_SR, 5'd11, OP_REG), '0);
    push_item(1'b0, enc_r(F7_BASE, 5'd3, 5'd1, F3_SLTU, 5'd13, OP_REG), '0);
    push_item(1'b0, enc_i(12'd0, 5'd0, F3_B, 5'd14, OP_LOAD), '0);
    push_item(1'b1, $urandom, 32'hFFFF_FF80);
    push_item(1'b0, enc_i(12'd2, 5'd0, F3_HU, 5'd15, OP_LOAD), '0);
    push_item(1'b0, enc_i(12'd0, 5'd0, F3_ADD, 5'd0, OP_IMM), '0);  // instruction while load pending
    push_item(1'b1, $urandom, 32'hFFFF_FFFF);
    push_item(1'b0, enc_i(12'd4, 5'd0, F3_W, 5'd16, OP_LOAD), '0);
    push_item(1'b1, $urandom, 32'h8000_0001);
    push_item(1'b1, $urandom, 32'h1234_5678);  // load data with nothing pending
    push_item(1'b0, enc_s(12'd1, 5'd1, 5'd3, F3_B), '0);
    push_item(1'b0, enc_s(12'hFFC, 5'd1, 5'd3, F3_W), '0);
    push_item(1'b0, enc_s(12'd0, 5'd1, 5'd4, F3_W), '0);        // outside the window
    push_item(1'b0, enc_i(12'd0, 5'd4, F3_W, 5'd18, OP_LOAD), '0);
    push_item(1'b0, enc_i(CSR_SCRATCH, 5'd1, F3_CSRRW, 5'd19, OP_SYSTEM), '0);
    push_item(1'b0, enc_i(CSR_SCRATCH, 5'd19, F3_CSRRS, 5'd19, OP_SYSTEM), '0);
    push_item(1'b0, enc_i(CSR_SCRATCH, 5'd31, F3_CSRRCI, 5'd20, OP_SYSTEM), '0);
    push_item(1'b0, enc_i(CSR_MCYCLE, 5'd0, F3_CSRRS, 5'd21, OP_SYSTEM), '0);
    push_item(1'b0, enc_i(CSR_SCRATCH, 5'd1, F3_CSR_RSVD, 5'd22, OP_SYSTEM), '0);
    push_item(1'b0, enc_i(IMM_EBREAK, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM), '0);
    push_item(1'b0, enc_i(IMM_ECALL, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM), '0);
    push_item(1'b0, {25'h1ABCDEF, OP_UNKNOWN}, '0);
    push_item(1'b0, enc_b(13'd8, 5'd0, 5'd0, F3_BEQ), '0);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_MEM_BASE, 32'h0);
          write_reg(CFG_ENTRY_PC, 32'h100);
          write_reg(CFG_INITIAL_SP, 32'h0);
        end
        1: begin
          write_reg(CFG_MEM_BASE, 32'hFFFF_F000);
          write_reg(CFG_ENTRY_PC, 32'hFFFF_F000);
          write_reg(CFG_INITIAL_SP, 32'hFFFF_FFFF);
        end
        default: begin
          write_reg(CFG_MEM_BASE, $urandom);
          write_reg(CFG_ENTRY_PC, mem_base + ($urandom_range(0, 32'hFFFFF) & ~32'd3));
          write_reg(CFG_INITIAL_SP, mem_base + $urandom_range(0, 32'h3FFFFFF));
        end
      endcase
      repeat (140) begin
        if (pend_vld) begin
          if ($urandom_range(0, 9) == 0) push_item(1'b0, $urandom, $urandom);
          else push_item(1'b1, $urandom, $urandom);
        end else if ($urandom_range(0, 99) < 3) begin
          push_item(1'b1, $urandom, $urandom);
        end else if ($urandom_range(0, 99) < 8) begin
          // point a register into the window, near its top edge now and then
          tgt = mem_base + (($urandom_range(0, 3) == 0) ? 32'(MEM_BYTES) - $urandom_range(1, 8)
                                                        : $urandom_range(0, 32'h3FFFFFF));
          hi = (tgt + 32'h800) >> 12;
          rd = 5'($urandom_range(1, 31));
          if (try_instr({hi[19:0], rd, OP_LUI}))
            void'(try_instr(enc_i(tgt[11:0], rd, F3_ADD, rd, OP_IMM)));
        end else begin
          for (int t = 0; t < 20; t++)
            if (try_instr(rand_instr())) break;
        end
      end
    end

    // Exit call, then items once halted
    drain();
    push_item(1'b0, enc_i(12'(ECALL_EXIT), 5'd0, F3_ADD, REG_A7, OP_IMM), '0);
    push_item(1'b0, enc_i(12'($urandom), 5'd0, F3_ADD, REG_A0, OP_IMM), '0);
    push_item(1'b0, enc_i(IMM_ECALL, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM), '0);
    push_item(1'b0, $urandom, $urandom);
    push_item(1'b1, $urandom, $urandom);
    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rdx_pkg.sv
rtl/core/rdx_exec.sv
rtl/core/rv32i_decode_execute_unit.sv
rtl/core/rdx_checker.sv
tb/testbench.sv
